>>> hdl/distance_vector_route_table_top_assert.svh
// Assertion macros for the distance-vector route table.
// Used by the top level only; no other dependencies.
`ifndef DISTANCE_VECTOR_ROUTE_TABLE_TOP_ASSERT_SVH
`define DISTANCE_VECTOR_ROUTE_TABLE_TOP_ASSERT_SVH
`define DVRT_ASSERT_IMPL(lbl, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
`define DVRT_ASSERT_NEXT(lbl, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`endif

>>> hdl/dvrt_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the distance-vector route table.
// No dependencies.
package dvrt_pkg;
  localparam logic [1:0] MODE_LINK = 2'd0;
  localparam logic [1:0] MODE_VBEGIN = 2'd1;
  localparam logic [1:0] MODE_VENTRY = 2'd2;
  localparam logic [1:0] MODE_LOOKUP = 2'd3;
  localparam logic [1:0] ST_LOCAL = 2'd0;
  localparam logic [1:0] ST_FWD = 2'd1;
  localparam logic [1:0] ST_NOROUTE = 2'd2;
  localparam logic [1:0] ST_LINKINF = 2'd3;
  localparam logic CFG_OWN_ID = 1'b0;
  localparam logic CFG_INF = 1'b1;
endpackage

>>> hdl/dvrt_walk_unit.sv
`timescale 1ns / 1ps
// Combinational arithmetic unit for the route walk: one route entry per call.
// Depends on dvrt_pkg.
module dvrt_walk_unit
  import dvrt_pkg::*;
(
  input  logic [15:0] route_cost,
  input  logic [15:0] delta_add,
  input  logic [15:0] delta_sub,
  input  logic [15:0] inf_cost,
  output logic [15:0] walk_cost
);
  logic signed [17:0] s;
  always_comb begin
    s = $signed({2'b00, route_cost}) + $signed({2'b00, delta_add})
        - $signed({2'b00, delta_sub});
    if (s < 0) walk_cost = 16'd0;
    else if (s > $signed({2'b00, inf_cost})) walk_cost = inf_cost;
    else walk_cost = s[15:0];
  end
endmodule

>>> hdl/distance_vector_route_table_top.sv
`timescale 1ns / 1ps
// Distance-vector route table: neighbor and route stores with a sequencer.
// Depends on dvrt_pkg, dvrt_walk_unit and the assertion macro header.
// A result is offered after its item passes S_RD, S_RD2 and S_EXEC; the next item is taken
// in the cycle after the result leaves, and no new item is taken while one is in flight.
// A cost change on a known link walks all NODES routes, with an S_WALK read and an S_WWR
// write per entry. Synchronous reset clears all valid bits at once.
`include "distance_vector_route_table_top_assert.svh"
module distance_vector_route_table_top
  import dvrt_pkg::*;
#(
  parameter int NODES = 64,
  parameter int PORTS = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // tdata: neighbor node, link port, destination, cost, self-entry flag
  input  logic [39:0] in_tdata,
  // tuser: mode
  input  logic [1:0] in_tuser,
  input  logic in_tlast,
  output logic out_tvalid,
  input  logic out_tready,
  // tdata: table_changed, advertise, lookup_status, egress port, hop node
  output logic [15:0] out_tdata,
  input  logic cfg_we,
  input  logic cfg_index,
  input  logic [15:0] cfg_wdata
);
  localparam int NW = $clog2(NODES);
  localparam int PW = (PORTS > 1) ? $clog2(PORTS) : 1;
  typedef enum logic [2:0] {S_IDLE, S_RD, S_RD2, S_EXEC, S_WALK, S_WWR, S_OUT} state_t;
  state_t state_r;
  logic [5:0] own_r; logic [15:0] inf_r;
  logic [1:0] mode_r; logic [5:0] nb_r; logic [3:0] port_r; logic [5:0] dest_r;
  logic [15:0] cost_r; logic self_r, last_r;
  logic [NODES-1:0] rv_r, nv_r;
  logic [15:0] rcost_m [NODES]; logic [5:0] rnh_m [NODES];
  logic [15:0] ncost_m [NODES]; logic [3:0] nport_m [NODES];
  logic [15:0] sender_r; logic vchg_r;
  logic [15:0] prev_r;
  logic [NW-1:0] idx_r;
  logic chg_r, adv_r; logic [1:0] st_r; logic [3:0] op_r; logic [5:0] onh_r;
  logic [15:0] rc_q, nc_q, nch_q; logic [5:0] rnh_q; logic [3:0] np_q;
  logic [15:0] wnc;
  logic [NW-1:0] ai;
  logic nb_ok, dst_ok;
  assign nb_ok = 32'(nb_r) < NODES;
  assign dst_ok = 32'(dest_r) < NODES;
  assign in_tready = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);
  assign out_tdata = {2'b00, onh_r, op_r, st_r, adv_r, chg_r};
  dvrt_walk_unit u_walk (.route_cost(rc_q), .delta_add(cost_r), .delta_sub(prev_r),
                         .inf_cost(inf_r), .walk_cost(wnc));
  always_comb begin
    if (state_r == S_WALK) ai = idx_r;
    else if (mode_r == MODE_VENTRY || mode_r == MODE_LOOKUP) ai = dest_r[NW-1:0];
    else ai = nb_r[NW-1:0];
  end
  // Registered reads of the route entry at ai, neighbor at ai and neighbor at next hop.
  always_ff @(posedge clk) begin
    rc_q <= rcost_m[ai]; rnh_q <= rnh_m[ai]; nc_q <= ncost_m[ai];
    nch_q <= ncost_m[rnh_q[NW-1:0]]; np_q <= nport_m[rnh_q[NW-1:0]];
  end
  logic [15:0] wr_c, d2; logic [5:0] wr_nh;
  logic wr_en, nvn, vb_upd, vb_diff, ve_upd, ve_diff;
  logic [15:0] ccap;
  logic [15:0] dc, vs;
  logic [16:0] vsum;
  always_comb begin
    ccap = (cost_r > inf_r) ? inf_r : cost_r;
    dc = nv_r[nb_r[NW-1:0]] ? nc_q : inf_r;
    vsum = {1'b0, sender_r} + {1'b0, ccap};
    vs = (vsum > {1'b0, inf_r}) ? inf_r : vsum[15:0];
  end
  always_comb begin
    nvn = !nv_r[nb_r[NW-1:0]] && self_r && 32'(port_r) < PORTS;
    d2 = nvn ? cost_r : dc;
    vb_upd = !rv_r[nb_r[NW-1:0]] || d2 < rc_q;
    vb_diff = vb_upd && (!rv_r[nb_r[NW-1:0]] || rc_q != d2 || rnh_q != nb_r);
    ve_upd = cost_r < inf_r && dest_r != own_r && (!rv_r[dest_r[NW-1:0]] || vs < rc_q);
    ve_diff = ve_upd && (!rv_r[dest_r[NW-1:0]] || rc_q != vs || rnh_q != nb_r);
    wr_en = 1'b0; wr_c = wnc; wr_nh = nb_r;
    if (rv_r[idx_r]) begin
      if (rnh_q == nb_r) begin
        wr_en = 1'b1;
        if (nv_r[idx_r] && nc_q < wnc) begin
          wr_c = nc_q; wr_nh = 6'(idx_r);
        end
      end else if (idx_r == nb_r[NW-1:0] && cost_r < rc_q) begin
        wr_en = 1'b1; wr_c = cost_r;
      end
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; own_r <= '0; inf_r <= 16'hFFFF; rv_r <= '0; nv_r <= '0;
      sender_r <= '0; vchg_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_OWN_ID) own_r <= cfg_wdata[5:0];
        else inf_r <= cfg_wdata;
      end
      unique case (state_r)
        S_IDLE: if (in_tvalid) begin
          mode_r <= in_tuser; nb_r <= in_tdata[5:0]; port_r <= in_tdata[9:6];
          dest_r <= in_tdata[15:10]; cost_r <= in_tdata[31:16]; self_r <= in_tdata[32];
          last_r <= in_tlast; state_r <= S_RD;
        end
        S_RD: begin
          cost_r <= ccap; chg_r <= 1'b0; adv_r <= 1'b0; st_r <= ST_LOCAL;
          op_r <= '0; onh_r <= '0; state_r <= S_RD2;
        end
        S_RD2: state_r <= S_EXEC;
        S_EXEC: begin
          state_r <= S_OUT;
          unique case (mode_r)
            MODE_LINK: if (nb_ok && 32'(port_r) < PORTS) begin
              adv_r <= 1'b1;
              ncost_m[nb_r[NW-1:0]] <= cost_r; nport_m[nb_r[NW-1:0]] <= port_r;
              nv_r[nb_r[NW-1:0]] <= 1'b1;
              if (!nv_r[nb_r[NW-1:0]]) begin
                if (!rv_r[nb_r[NW-1:0]] || cost_r < rc_q) begin
                  chg_r <= !rv_r[nb_r[NW-1:0]] || rc_q != cost_r || rnh_q != nb_r;
                  rv_r[nb_r[NW-1:0]] <= 1'b1; rcost_m[nb_r[NW-1:0]] <= cost_r;
                  rnh_m[nb_r[NW-1:0]] <= nb_r;
                end
              end else if (nc_q != cost_r) begin
                prev_r <= nc_q; idx_r <= '0; state_r <= S_WALK;
              end
            end
            MODE_VBEGIN: if (nb_ok) begin
              if (nvn) begin
                nv_r[nb_r[NW-1:0]] <= 1'b1; ncost_m[nb_r[NW-1:0]] <= cost_r;
                nport_m[nb_r[NW-1:0]] <= port_r;
              end
              if (vb_upd) begin
                rv_r[nb_r[NW-1:0]] <= 1'b1; rcost_m[nb_r[NW-1:0]] <= d2;
                rnh_m[nb_r[NW-1:0]] <= nb_r; sender_r <= d2;
              end else begin
                sender_r <= rc_q;
              end
              chg_r <= vb_diff;
              vchg_r <= last_r ? 1'b0 : vb_diff;
              adv_r <= last_r & vb_diff;
            end
            MODE_VENTRY: if (nb_ok && dst_ok) begin
              if (ve_upd) begin
                rv_r[dest_r[NW-1:0]] <= 1'b1; rcost_m[dest_r[NW-1:0]] <= vs;
                rnh_m[dest_r[NW-1:0]] <= nb_r;
              end
              chg_r <= ve_diff;
              vchg_r <= last_r ? 1'b0 : (vchg_r | ve_diff);
              adv_r <= last_r & (vchg_r | ve_diff);
            end
            default: begin
              if (dest_r == own_r) st_r <= ST_LOCAL;
              else if (!dst_ok || !rv_r[dest_r[NW-1:0]]) st_r <= ST_NOROUTE;
              else begin
                onh_r <= rnh_q;
                if (32'(rnh_q) < NODES && nv_r[rnh_q[NW-1:0]] && nch_q < inf_r) begin
                  st_r <= ST_FWD; op_r <= np_q;
                end else st_r <= ST_LINKINF;
              end
            end
          endcase
        end
        S_WALK: state_r <= S_WWR;
        S_WWR: begin
          if (wr_en) begin
            rcost_m[idx_r] <= wr_c; rnh_m[idx_r] <= wr_nh;
            if (rc_q != wr_c || rnh_q != wr_nh) chg_r <= 1'b1;
          end
          if (idx_r == NW'(NODES - 1)) state_r <= S_OUT;
          else begin
            idx_r <= idx_r + 1'b1; state_r <= S_WALK;
          end
        end
        S_OUT: if (out_tready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end
  `DVRT_ASSERT_IMPL(a_excl, out_tvalid, !in_tready, "input taken while result pending")
  `DVRT_ASSERT_NEXT(a_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata),
                    "result dropped")
  `DVRT_ASSERT_IMPL(a_port, out_tvalid && out_tdata[3:2] != ST_FWD, out_tdata[7:4] == 4'd0,
                    "port without forward")
endmodule
